// ===== hdl/hrbp_pkg.sv =====
// Shared types, constants and method table for the HTTP request byte parser.
package hrbp_pkg;

    // Method bytes kept for matching; must be at least the longest method name.
    localparam int METHOD_CHARS = 7;
    localparam int MLEN_W       = $clog2(METHOD_CHARS + 2);
    localparam int MIDX_W       = $clog2(METHOD_CHARS);

    localparam int NUM_METHODS = 9;
    localparam int NAME_MAX    = 7;

    localparam int LEN_W = 17;
    localparam logic [LEN_W-1:0] LIMIT_RESET = 17'h10000;

    // At most four results follow from one input byte.
    localparam int MAX_RES = 4;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_RES,
        PH_PROTO,
        PH_HNAME,
        PH_HVAL,
        PH_BODY,
        PH_DISCARD
    } phase_t;

    typedef enum logic [2:0] {
        EV_BYTE,
        EV_CLOSE,
        EV_ABANDON,
        EV_ACCEPT,
        EV_REJECT
    } event_t;

    typedef enum logic [2:0] {
        KIND_METHOD,
        KIND_PATH,
        KIND_QUERY,
        KIND_PROTO,
        KIND_HNAME,
        KIND_HVAL,
        KIND_BODY
    } kind_t;

    typedef enum logic {
        ERR_METHOD,
        ERR_TOO_LONG
    } err_t;

    typedef struct packed {
        event_t     ev;
        kind_t      kind;
        logic [7:0] data;
        logic [3:0] method;
        err_t       err;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0]          cnt;
        res_t [MAX_RES-1:0]        res;
    } bundle_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    localparam logic [7:0] METHOD_TEXT [NUM_METHODS][NAME_MAX] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00},
        '{"P", "A", "T", "C", "H", 8'h00, 8'h00},
        '{"O", "P", "T", "I", "O", "N", "S"},
        '{"T", "R", "A", "C", "E", 8'h00, 8'h00},
        '{"C", "O", "N", "N", "E", "C", "T"},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [MLEN_W-1:0] METHOD_LEN [NUM_METHODS] = '{
        MLEN_W'(3), MLEN_W'(4), MLEN_W'(4), MLEN_W'(6), MLEN_W'(5),
        MLEN_W'(7), MLEN_W'(5), MLEN_W'(7), MLEN_W'(3)
    };

endpackage

// ===== hdl/http_request_byte_parser_unit.sv =====
// HTTP request byte parser: one request byte in per cycle while the queue has room, tagged field events out.
// The front end takes a byte whenever its two-entry bundle queue has room, and turns
// it into between zero and four results; the back end sends those out one per cycle,
// while the output port takes them, through an output register. A byte causes one
// result for a plain field byte, two where a held CR or colon is released as data
// alongside the next byte, and up to four at the end of a request, so the output port
// sets the pace. The field length limit may be changed only while the block is idle;
// it resets to 65536. No clearing pass is needed after reset.
module http_request_byte_parser_unit import hrbp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_end_of_request,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_event_res,
    output logic [2:0]       m_field_kind,
    output logic [7:0]       m_byte_out,
    output logic [3:0]       m_method_code,
    output logic             m_error_code,
    output logic             m_last_of_run
);

    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    bundle_t q_wdata;
    bundle_t q_head;

    hrbp_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_request (s_end_of_request),
        .q_stat           (q_stat),
        .q_push           (q_push),
        .q_wdata          (q_wdata)
    );

    hrbp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .head    (q_head),
        .stat    (q_stat)
    );

    hrbp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_head        (q_head),
        .q_stat        (q_stat),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_field_kind  (m_field_kind),
        .m_byte_out    (m_byte_out),
        .m_method_code (m_method_code),
        .m_error_code  (m_error_code),
        .m_last_of_run (m_last_of_run)
    );

    // The front end must never write into a full queue.
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("bundle pushed into a full queue");

    // The back end must never take a bundle from an empty queue.
    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("bundle popped from an empty queue");

    // Every queued bundle carries at least one result and no more than the slots hold.
    a_bundle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_wdata.cnt != '0) && (q_wdata.cnt <= CNT_W'(MAX_RES)))
        else $error("queued bundle has an impossible result count");

    // Accept and reject always finish the run of results for their byte.
    a_verdict_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_res == EV_ACCEPT || m_event_res == EV_REJECT))
            |-> m_last_of_run)
        else $error("verdict result not marked as last of its run");

endmodule

// ===== hdl/hrbp_front.sv =====
// Front end: accepts request bytes, tracks the parse and builds each byte's result bundle.
module hrbp_front import hrbp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_end_of_request,
    input  q_stat_t          q_stat,
    output logic             q_push,
    output bundle_t          q_wdata
);

    typedef struct packed {
        phase_t                         phase;
        logic                           held_valid;
        logic [7:0]                     held_byte;
        logic [LEN_W-1:0]               flen;
        logic [METHOD_CHARS-1:0][7:0]   mchars;
        logic [MLEN_W-1:0]              mlen;
        logic                           in_query;
    } parse_st_t;

    typedef struct packed {
        parse_st_t st;
        res_t      res;
        logic      ok;
    } data_ret_t;

    typedef struct packed {
        parse_st_t st;
        res_t      res;
        logic      emit;
    } step_ret_t;

    typedef struct packed {
        logic       found;
        logic [3:0] code;
    } lookup_t;

    typedef struct packed {
        parse_st_t st;
        bundle_t   bundle;
    } walk_t;

    parse_st_t        st_reg, st_next;
    logic [LEN_W-1:0] lim_reg, lim_next;
    walk_t            walk;
    logic             accept;

    function automatic res_t make_res(event_t ev, kind_t kind, logic [7:0] data,
                                      logic [3:0] method, err_t err);
        res_t r;
        r.ev     = ev;
        r.kind   = kind;
        r.data   = data;
        r.method = method;
        r.err    = err;
        return r;
    endfunction

    function automatic kind_t cur_kind(parse_st_t s);
        kind_t k;
        case (s.phase)
            PH_METHOD: k = KIND_METHOD;
            PH_RES:    k = s.in_query ? KIND_QUERY : KIND_PATH;
            PH_PROTO:  k = KIND_PROTO;
            PH_HNAME:  k = KIND_HNAME;
            PH_HVAL:   k = KIND_HVAL;
            default:   k = KIND_BODY;
        endcase
        return k;
    endfunction

    function automatic res_t close_res(parse_st_t s);
        return make_res(EV_CLOSE, cur_kind(s), 8'h00, 4'h0, ERR_METHOD);
    endfunction

    // One field byte: either counted and reported, or the request is rejected as too long.
    function automatic data_ret_t do_data(parse_st_t s, logic [7:0] b, logic [LEN_W-1:0] lim);
        data_ret_t r;
        r.st  = s;
        r.ok  = 1'b1;
        r.res = '0;
        if (s.flen >= lim) begin
            r.res          = make_res(EV_REJECT, KIND_METHOD, 8'h00, 4'h0, ERR_TOO_LONG);
            r.st.phase     = PH_DISCARD;
            r.st.held_valid = 1'b0;
            r.st.held_byte = 8'h00;
            r.ok           = 1'b0;
        end else begin
            r.st.flen = s.flen + LEN_W'(1);
            if (s.phase == PH_METHOD) begin
                if (s.mlen < MLEN_W'(METHOD_CHARS)) begin
                    r.st.mchars[s.mlen[MIDX_W-1:0]] = b;
                    r.st.mlen = s.mlen + MLEN_W'(1);
                end else begin
                    r.st.mlen = MLEN_W'(METHOD_CHARS + 1);
                end
            end
            r.res = make_res(EV_BYTE, cur_kind(s), b, 4'h0, ERR_METHOD);
        end
        return r;
    endfunction

    function automatic step_ret_t do_process(parse_st_t s, logic [7:0] b,
                                             logic [LEN_W-1:0] lim);
        step_ret_t r;
        data_ret_t d;
        d      = do_data(s, b, lim);
        r.st   = s;
        r.res  = '0;
        r.emit = 1'b0;
        case (s.phase)
            PH_METHOD: begin
                if (b == CH_SP) begin
                    r.res      = close_res(s);
                    r.emit     = 1'b1;
                    r.st.flen  = '0;
                    r.st.phase = PH_RES;
                end else begin
                    r.st   = d.st;
                    r.res  = d.res;
                    r.emit = 1'b1;
                end
            end
            PH_RES: begin
                if (b == CH_SP) begin
                    r.res         = close_res(s);
                    r.emit        = 1'b1;
                    r.st.flen     = '0;
                    r.st.in_query = 1'b0;
                    r.st.phase    = PH_PROTO;
                end else if (b == CH_QMARK && !s.in_query) begin
                    r.res         = close_res(s);
                    r.emit        = 1'b1;
                    r.st.flen     = '0;
                    r.st.in_query = 1'b1;
                end else begin
                    r.st   = d.st;
                    r.res  = d.res;
                    r.emit = 1'b1;
                end
            end
            PH_PROTO, PH_HVAL: begin
                if (b == CH_CR) begin
                    r.st.held_valid = 1'b1;
                    r.st.held_byte  = b;
                end else begin
                    r.st   = d.st;
                    r.res  = d.res;
                    r.emit = 1'b1;
                end
            end
            PH_HNAME: begin
                // A CR can only start the blank line when no name byte has been seen.
                if ((b == CH_CR && s.flen == '0) || b == CH_COLON) begin
                    r.st.held_valid = 1'b1;
                    r.st.held_byte  = b;
                end else begin
                    r.st   = d.st;
                    r.res  = d.res;
                    r.emit = 1'b1;
                end
            end
            PH_BODY: begin
                r.st   = d.st;
                r.res  = d.res;
                r.emit = 1'b1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic lookup_t lookup_method(logic [METHOD_CHARS-1:0][7:0] mc,
                                              logic [MLEN_W-1:0] ml);
        lookup_t r;
        logic    match;
        r.found = 1'b0;
        r.code  = 4'h0;
        for (int m = 0; m < NUM_METHODS; m++) begin
            match = (ml == METHOD_LEN[m]);
            for (int i = 0; i < NAME_MAX; i++) begin
                if (MLEN_W'(i) < METHOD_LEN[m] && mc[i] != METHOD_TEXT[m][i]) begin
                    match = 1'b0;
                end
            end
            if (match && !r.found) begin
                r.found = 1'b1;
                r.code  = 4'(m);
            end
        end
        return r;
    endfunction

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    // Walk one byte through the parse, exactly as the byte-level rules order it.
    always_comb begin
        parse_st_t            st;
        res_t [MAX_RES-1:0]   res;
        logic [CNT_W-1:0]     n;
        data_ret_t            d;
        step_ret_t            p;
        lookup_t              lk;
        logic [7:0]           h;
        st  = st_reg;
        res = '0;
        n   = '0;
        d   = '0;
        p   = '0;
        lk  = '0;
        h   = 8'h00;
        if (st.held_valid) begin
            h             = st.held_byte;
            st.held_valid = 1'b0;
            st.held_byte  = 8'h00;
            if (h == CH_CR && s_data_byte == CH_LF) begin
                if (st.phase == PH_HNAME) begin
                    st.phase = PH_BODY;
                    st.flen  = '0;
                end else begin
                    res[n[IDX_W-1:0]] = close_res(st);
                    n        = n + CNT_W'(1);
                    st.flen  = '0;
                    st.phase = PH_HNAME;
                end
            end else if (h == CH_COLON && s_data_byte == CH_SP) begin
                res[n[IDX_W-1:0]] = close_res(st);
                n        = n + CNT_W'(1);
                st.flen  = '0;
                st.phase = PH_HVAL;
            end else begin
                d  = do_data(st, h, lim_reg);
                st = d.st;
                res[n[IDX_W-1:0]] = d.res;
                n  = n + CNT_W'(1);
                if (d.ok) begin
                    p  = do_process(st, s_data_byte, lim_reg);
                    st = p.st;
                    if (p.emit) begin
                        res[n[IDX_W-1:0]] = p.res;
                        n = n + CNT_W'(1);
                    end
                end
            end
        end else begin
            p  = do_process(st, s_data_byte, lim_reg);
            st = p.st;
            if (p.emit) begin
                res[n[IDX_W-1:0]] = p.res;
                n = n + CNT_W'(1);
            end
        end

        if (s_end_of_request) begin
            if (st.held_valid) begin
                h             = st.held_byte;
                st.held_valid = 1'b0;
                st.held_byte  = 8'h00;
                d  = do_data(st, h, lim_reg);
                st = d.st;
                res[n[IDX_W-1:0]] = d.res;
                n  = n + CNT_W'(1);
            end
            case (st.phase)
                PH_METHOD, PH_RES, PH_PROTO, PH_BODY: begin
                    res[n[IDX_W-1:0]] = close_res(st);
                    n = n + CNT_W'(1);
                end
                PH_HNAME: begin
                    if (st.flen != '0) begin
                        res[n[IDX_W-1:0]] = make_res(EV_ABANDON, KIND_HNAME, 8'h00, 4'h0,
                                                     ERR_METHOD);
                        n = n + CNT_W'(1);
                    end
                end
                PH_HVAL: begin
                    res[n[IDX_W-1:0]] = make_res(EV_ABANDON, KIND_HVAL, 8'h00, 4'h0,
                                                 ERR_METHOD);
                    n = n + CNT_W'(1);
                end
                default: begin
                end
            endcase
            if (st.phase != PH_DISCARD) begin
                lk = lookup_method(st.mchars, st.mlen);
                if (st.phase == PH_METHOD || !lk.found) begin
                    res[n[IDX_W-1:0]] = make_res(EV_REJECT, KIND_METHOD, 8'h00, 4'h0,
                                                 ERR_METHOD);
                end else begin
                    res[n[IDX_W-1:0]] = make_res(EV_ACCEPT, KIND_METHOD, 8'h00, lk.code,
                                                 ERR_METHOD);
                end
                n = n + CNT_W'(1);
            end
            st       = '0;
            st.phase = PH_METHOD;
        end
        walk.st         = st;
        walk.bundle.cnt = n;
        walk.bundle.res = res;
    end

    always_comb begin
        st_next  = accept ? walk.st : st_reg;
        lim_next = cfg_wr_en ? cfg_wr_data : lim_reg;
    end

    // A byte that produces nothing (for example while discarding) is not queued.
    always_comb begin
        q_push  = accept && (walk.bundle.cnt != '0);
        q_wdata = walk.bundle;
    end

    // An all-zero parse state is the method phase with nothing held.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= '0;
            lim_reg <= LIMIT_RESET;
        end else begin
            st_reg  <= st_next;
            lim_reg <= lim_next;
        end
    end

endmodule

// ===== hdl/hrbp_queue.sv =====
// Short queue of result bundles between the front and back ends.
module hrbp_queue import hrbp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t wdata,
    input  logic    pop,
    output bundle_t head,
    output q_stat_t stat
);

    bundle_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/hrbp_back.sv =====
// Back end: serialises each queued bundle into single results behind an output register.
module hrbp_back import hrbp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  bundle_t    q_head,
    input  q_stat_t    q_stat,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_res,
    output logic [2:0] m_field_kind,
    output logic [7:0] m_byte_out,
    output logic [3:0] m_method_code,
    output logic       m_error_code,
    output logic       m_last_of_run
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    res_t             out_reg, out_next;
    logic             last_reg, last_next;
    logic             load;
    logic             is_last;

    // With a bundle queued, the output register reloads if empty or its result is taken.
    assign load    = !q_stat.empty && (!m_valid_reg || m_ready);
    assign is_last = (CNT_W'(idx_reg) + CNT_W'(1)) == q_head.cnt;
    assign q_pop   = load && is_last;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        last_next    = last_reg;
        if (load) begin
            out_next     = q_head.res[idx_reg];
            last_next    = is_last;
            m_valid_next = 1'b1;
            idx_next     = is_last ? '0 : idx_reg + IDX_W'(1);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_event_res   = out_reg.ev;
    assign m_field_kind  = out_reg.kind;
    assign m_byte_out    = out_reg.data;
    assign m_method_code = out_reg.method;
    assign m_error_code  = out_reg.err;
    assign m_last_of_run = last_reg;

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
